// ----- hdl/temperature_alarm_with_encoder_setting_assert.svh -----
// Assertion macros shared by the alarm RTL. Clock aclk, reset aresetn (active low).
`ifndef TEMPERATURE_ALARM_WITH_ENCODER_SETTING_ASSERT_SVH
`define TEMPERATURE_ALARM_WITH_ENCODER_SETTING_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property outside reset.
`define TAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TAE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define TAE_ASSERT(lbl, prop, msg)
`define TAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/tae_pkg.sv -----
package tae_pkg;

    localparam int CMD_W    = 2;
    localparam int RAW_W    = 12;
    localparam int NOTE_W   = 5;
    localparam int THRESH_W = 7;
    localparam int TEMP_W   = 14;

    localparam int NUM_NOTES_DEF = 25;

    localparam int THRESH_MIN   = 60;
    localparam int THRESH_MAX   = 100;
    localparam int THRESH_RESET = 80;
    localparam int NOTE_RESET   = 10;
    localparam int HOT_MARGIN   = 32;
    localparam int F_OFFSET     = 512;

    // Input beat: tdata = raw_celsius, enc_a, enc_b, note_button_n, thresh_button_n
    localparam int S_TDATA_W = 16;
    // Result beat: alarm_state .. temp_f16 = 33 bits, padded to whole bytes
    localparam int M_FIELDS_W = 33;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_ENCODER = 2'd1,
        CMD_BUTTONS = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        BAND_COOL = 2'd0,
        BAND_WARM = 2'd1,
        BAND_HOT  = 2'd2
    } band_t;

endpackage

// ----- hdl/temperature_alarm_with_encoder_setting.sv -----
// A beat accepted on s_* waits in the input register, then moves into the result register on m_*.
// Throughput: one beat per cycle while m_tready is high; an input register and a result register
// part the two sides, so a new beat is taken while a finished result still waits on m_tready.
// Reset (aresetn low, synchronous): both stages empty, band cool, threshold 80 F,
// note 10 (or NUM_NOTES-1 if smaller), encoder phase 0, note edited, temperature 0.
`include "temperature_alarm_with_encoder_setting_assert.svh"

module temperature_alarm_with_encoder_setting #(
    parameter int NUM_NOTES = tae_pkg::NUM_NOTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] raw_celsius, [12] enc_a, [13] enc_b, [14] note_button_n, [15] thresh_button_n
    input  logic [tae_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [tae_pkg::CMD_W-1:0]       s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] alarm_state, [2] green_led, [3] red_led, [4] blink_enable, [5] tone_start,
    // [10:6] alert_note, [17:11] threshold_f, [18] edit_target, [32:19] temp_f16, rest zero
    output logic [tae_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int NW = tae_pkg::NOTE_W;
    localparam int TW = tae_pkg::THRESH_W;

    localparam logic [NW-1:0] NOTE_MAX  = NW'(NUM_NOTES - 1);
    localparam logic [NW-1:0] NOTE_INIT = (tae_pkg::NOTE_RESET < NUM_NOTES) ?
                                          NW'(tae_pkg::NOTE_RESET) : NW'(NUM_NOTES - 1);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                              in_valid_reg;
    logic [tae_pkg::CMD_W-1:0]         in_cmd_reg;
    logic signed [tae_pkg::RAW_W-1:0]  in_raw_reg;
    logic                              in_a_reg;
    logic                              in_b_reg;
    logic                              in_note_btn_n_reg;
    logic                              in_thresh_btn_n_reg;

    // Advance: the held beat moves into the result register this edge.
    logic advance;

    logic                              out_valid_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset: capture on every accepted beat.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg          <= s_tuser;
            in_raw_reg          <= s_tdata[11:0];
            in_a_reg            <= s_tdata[12];
            in_b_reg            <= s_tdata[13];
            in_note_btn_n_reg   <= s_tdata[14];
            in_thresh_btn_n_reg <= s_tdata[15];
        end
    end

    // ---------------------------------------------------------------
    // Settings and encoder state
    // ---------------------------------------------------------------
    logic [TW-1:0]                     threshold_reg, threshold_next;
    logic [NW-1:0]                     note_reg, note_next;
    logic [1:0]                        phase_reg, phase_next;
    logic                              edit_reg, edit_next;
    logic signed [tae_pkg::TEMP_W-1:0] temp_reg, temp_next;
    tae_pkg::band_t                    band_reg, band_next;

    logic signed [tae_pkg::TEMP_W-1:0] conv_temp;

    tae_f_convert u_f_convert (
        .raw_celsius (in_raw_reg),
        .temp_f16    (conv_temp)
    );

    // Quadrature decode: first matching rule for the current phase wins.
    logic [1:0]         enc_phase;
    logic signed [1:0]  enc_step;

    always_comb begin
        enc_phase = phase_reg;
        enc_step  = 2'sd0;
        unique case (phase_reg)
            2'd0: begin
                if (in_a_reg) begin
                    enc_phase = 2'd1; enc_step = 2'sd1;
                end else if (in_b_reg) begin
                    enc_phase = 2'd2; enc_step = -2'sd1;
                end
            end
            2'd1: begin
                if (in_b_reg) begin
                    enc_phase = 2'd3; enc_step = 2'sd1;
                end else if (!in_a_reg) begin
                    enc_phase = 2'd0; enc_step = -2'sd1;
                end
            end
            2'd2: begin
                if (!in_b_reg) begin
                    enc_phase = 2'd0; enc_step = 2'sd1;
                end else if (in_a_reg) begin
                    enc_phase = 2'd3; enc_step = -2'sd1;
                end
            end
            default: begin
                if (!in_b_reg) begin
                    enc_phase = 2'd1; enc_step = -2'sd1;
                end else if (!in_a_reg) begin
                    enc_phase = 2'd2; enc_step = 2'sd1;
                end
            end
        endcase
    end

    // Step the edited setting and clamp it to its range, step or not.
    logic signed [NW+1:0] note_sum;
    logic signed [TW+1:0] thresh_sum;
    logic [NW-1:0]        note_clamped;
    logic [TW-1:0]        thresh_clamped;

    assign note_sum   = $signed({2'b00, note_reg}) + (NW+2)'(enc_step);
    assign thresh_sum = $signed({2'b00, threshold_reg}) + (TW+2)'(enc_step);

    always_comb begin
        if (note_sum < 0) begin
            note_clamped = '0;
        end else if (note_sum > $signed({2'b00, NOTE_MAX})) begin
            note_clamped = NOTE_MAX;
        end else begin
            note_clamped = note_sum[NW-1:0];
        end

        if (thresh_sum < (TW+2)'(tae_pkg::THRESH_MIN)) begin
            thresh_clamped = TW'(tae_pkg::THRESH_MIN);
        end else if (thresh_sum > (TW+2)'(tae_pkg::THRESH_MAX)) begin
            thresh_clamped = TW'(tae_pkg::THRESH_MAX);
        end else begin
            thresh_clamped = thresh_sum[TW-1:0];
        end
    end

    // Apply the beat's command; an unused code leaves every setting alone.
    always_comb begin
        threshold_next = threshold_reg;
        note_next      = note_reg;
        phase_next     = phase_reg;
        edit_next      = edit_reg;
        temp_next      = temp_reg;
        if (advance) begin
            unique case (in_cmd_reg)
                tae_pkg::CMD_SAMPLE: begin
                    temp_next = conv_temp;
                end
                tae_pkg::CMD_ENCODER: begin
                    phase_next = enc_phase;
                    if (edit_reg) begin
                        threshold_next = thresh_clamped;
                    end else begin
                        note_next = note_clamped;
                    end
                end
                tae_pkg::CMD_BUTTONS: begin
                    // Note button has priority; no press keeps the target.
                    if (!in_note_btn_n_reg) begin
                        edit_next = 1'b0;
                    end else if (!in_thresh_btn_n_reg) begin
                        edit_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Band machine: d = temperature - 16*threshold, both after this beat
    // ---------------------------------------------------------------
    logic signed [15:0] diff;
    logic               tone_next;

    assign diff = 16'(temp_next) - $signed({5'b0, threshold_next, 4'b0});

    always_comb begin
        band_next = band_reg;
        tone_next = 1'b0;
        if (advance) begin
            unique case (band_reg)
                tae_pkg::BAND_COOL: begin
                    if (diff > 16'sd0) begin
                        if (diff > 16'(tae_pkg::HOT_MARGIN)) begin
                            band_next = tae_pkg::BAND_HOT;
                            tone_next = 1'b1;
                        end else begin
                            band_next = tae_pkg::BAND_WARM;
                        end
                    end
                end
                tae_pkg::BAND_WARM: begin
                    if (diff <= 16'sd0) begin
                        band_next = tae_pkg::BAND_COOL;
                    end else if (diff > 16'(tae_pkg::HOT_MARGIN)) begin
                        band_next = tae_pkg::BAND_HOT;
                        tone_next = 1'b1;
                    end
                end
                default: begin
                    if (diff <= 16'sd0) begin
                        band_next = tae_pkg::BAND_COOL;
                    end else if (diff < 16'(tae_pkg::HOT_MARGIN)) begin
                        band_next = tae_pkg::BAND_WARM;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg      <= tae_pkg::BAND_COOL;
            threshold_reg <= TW'(tae_pkg::THRESH_RESET);
            note_reg      <= NOTE_INIT;
            phase_reg     <= 2'd0;
            edit_reg      <= 1'b0;
            temp_reg      <= '0;
        end else begin
            band_reg      <= band_next;
            threshold_reg <= threshold_next;
            note_reg      <= note_next;
            phase_reg     <= phase_next;
            edit_reg      <= edit_next;
            temp_reg      <= temp_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    tae_pkg::band_t                    out_band_reg;
    logic                              out_tone_reg;
    logic [NW-1:0]                     out_note_reg;
    logic [TW-1:0]                     out_thresh_reg;
    logic                              out_edit_reg;
    logic signed [tae_pkg::TEMP_W-1:0] out_temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result until taken; load a new one on advance.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_band_reg   <= band_next;
            out_tone_reg   <= tone_next;
            out_note_reg   <= note_next;
            out_thresh_reg <= threshold_next;
            out_edit_reg   <= edit_next;
            out_temp_reg   <= temp_next;
        end
    end

    logic green_led, red_led, blink_enable;

    assign green_led    = (out_band_reg == tae_pkg::BAND_COOL);
    assign red_led      = (out_band_reg == tae_pkg::BAND_HOT);
    assign blink_enable = (out_band_reg == tae_pkg::BAND_WARM);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(tae_pkg::M_TDATA_W - tae_pkg::M_FIELDS_W)'(0),
                       out_temp_reg, out_edit_reg, out_thresh_reg, out_note_reg,
                       out_tone_reg, blink_enable, red_led, green_led, out_band_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TAE_ASSERT(a_thresh_range,
        (threshold_reg >= TW'(tae_pkg::THRESH_MIN)) && (threshold_reg <= TW'(tae_pkg::THRESH_MAX)),
        "threshold left its range")
    `TAE_ASSERT(a_note_range, note_reg <= NOTE_MAX, "alert note beyond last note")
    `TAE_ASSERT(a_tone_hot,
        out_valid_reg && out_tone_reg |-> out_band_reg == tae_pkg::BAND_HOT,
        "tone pulse outside hot band")
    `TAE_ASSERT(a_in_hold, in_valid_reg && !advance |=> in_valid_reg, "held input beat dropped")
    `TAE_ASSERT(a_settings_idle,
        !advance |=> $stable(threshold_reg) && $stable(note_reg) && $stable(band_reg),
        "state moved without a beat")
    `TAE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid && s_tready,
        "pipeline not empty after reset")

endmodule

// ----- hdl/tae_f_convert.sv -----
// Celsius*16 to Fahrenheit*16: trunc(raw*9/5) + 512, truncation toward zero.
module tae_f_convert (
    input  logic signed [tae_pkg::RAW_W-1:0]  raw_celsius,
    output logic signed [tae_pkg::TEMP_W-1:0] temp_f16
);

    // floor(m/5) == (m*RECIP5) >> RECIP5_SHIFT exactly for m below 2^18
    localparam logic [31:0] RECIP5       = 32'd52429;
    localparam int          RECIP5_SHIFT = 18;

    logic signed [15:0] raw_ext;
    logic signed [15:0] times9;
    logic               neg;
    logic [14:0]        mag;
    logic [31:0]        prod;
    logic [12:0]        quo;
    logic signed [13:0] quo_signed;

    assign raw_ext = 16'(raw_celsius);
    assign times9  = (raw_ext <<< 3) + raw_ext;
    assign neg     = times9[15];
    assign mag     = neg ? 15'(-times9) : times9[14:0];
    assign prod    = {17'b0, mag} * RECIP5;
    assign quo     = prod[RECIP5_SHIFT+12:RECIP5_SHIFT];

    assign quo_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign temp_f16   = quo_signed + 14'(tae_pkg::F_OFFSET);

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

    // Command code that the block must treat as a no-op apart from the band update.
    localparam logic [tae_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Quadrature phases, named by which encoder channels are high.
    localparam logic [1:0] ENC_REST = 2'd0;
    localparam logic [1:0] ENC_A    = 2'd1;
    localparam logic [1:0] ENC_B    = 2'd2;
    localparam logic [1:0] ENC_AB   = 2'd3;

    localparam int RANDOM_BEATS = 1850;
    localparam int IDLE_LIMIT   = 1000;
    localparam int NOTE_TOP     = tae_pkg::NUM_NOTES_DEF - 1;

    // Result beat as packed on m_tdata, highest field first.
    typedef struct packed {
        logic [tae_pkg::M_TDATA_W-tae_pkg::M_FIELDS_W-1:0] pad;
        logic [tae_pkg::TEMP_W-1:0]                        temp_f16;
        logic                                              edit_target;
        logic [tae_pkg::THRESH_W-1:0]                      threshold_f;
        logic [tae_pkg::NOTE_W-1:0]                        alert_note;
        logic                                              tone_start;
        logic                                              blink_enable;
        logic                                              red_led;
        logic                                              green_led;
        logic [1:0]                                        alarm_state;
    } alarm_result_t;

    // Alarm predictor plus the queue of results it has promised.
    class alarm_scoreboard;
        tae_pkg::band_t band;
        int             threshold;
        int             note;
        logic [1:0]     enc_phase;
        logic           edit_thr;
        int             temp_f16;
        alarm_result_t  predicted[$];
        int             mismatches;
        int             results_seen;
        int             cmd_count[4];
        int             hot_entries;
        int             note_lo, note_hi, thr_lo, thr_hi;

        function new();
            band      = tae_pkg::BAND_COOL;
            threshold = tae_pkg::THRESH_RESET;
            note      = (tae_pkg::NOTE_RESET < tae_pkg::NUM_NOTES_DEF) ?
                        tae_pkg::NOTE_RESET : NOTE_TOP;
            enc_phase = ENC_REST;
            edit_thr  = 1'b0;
            temp_f16  = 0;
            note_lo   = note;
            note_hi   = note;
            thr_lo    = threshold;
            thr_hi    = threshold;
        endfunction

        // Walk the quadrature decoder one event; return the step -1, 0 or +1.
        function int encoder_walk(logic a, logic b);
            case (enc_phase)
                ENC_REST: begin
                    if (a) begin enc_phase = ENC_A; return 1; end
                    if (b) begin enc_phase = ENC_B; return -1; end
                end
                ENC_A: begin
                    if (b)  begin enc_phase = ENC_AB;   return 1; end
                    if (!a) begin enc_phase = ENC_REST; return -1; end
                end
                ENC_B: begin
                    if (!b) begin enc_phase = ENC_REST; return 1; end
                    if (a)  begin enc_phase = ENC_AB;   return -1; end
                end
                default: begin
                    if (!b) begin enc_phase = ENC_A; return -1; end
                    if (!a) begin enc_phase = ENC_B; return 1; end
                end
            endcase
            return 0;
        endfunction

        // Advance the predictor on one accepted input beat and queue its result.
        function void note_beat(logic [tae_pkg::CMD_W-1:0] cmd,
                                logic [tae_pkg::S_TDATA_W-1:0] data);
            int            raw;
            int            step;
            int            diff;
            logic          tone;
            alarm_result_t r;
            tone = 1'b0;
            cmd_count[cmd]++;
            case (cmd)
                tae_pkg::CMD_SAMPLE: begin
                    raw      = int'($signed(data[tae_pkg::RAW_W-1:0]));
                    temp_f16 = (raw * 9) / 5 + tae_pkg::F_OFFSET;
                end
                tae_pkg::CMD_ENCODER: begin
                    step = encoder_walk(data[12], data[13]);
                    if (edit_thr) begin
                        threshold = threshold + step;
                        if (threshold < tae_pkg::THRESH_MIN) threshold = tae_pkg::THRESH_MIN;
                        if (threshold > tae_pkg::THRESH_MAX) threshold = tae_pkg::THRESH_MAX;
                    end else begin
                        note = note + step;
                        if (note < 0) note = 0;
                        if (note > NOTE_TOP) note = NOTE_TOP;
                    end
                end
                tae_pkg::CMD_BUTTONS: begin
                    // Note button wins when both are held; none held keeps the mode.
                    if (!data[14]) edit_thr = 1'b0;
                    else if (!data[15]) edit_thr = 1'b1;
                end
                default: ;
            endcase

            diff = temp_f16 - threshold * 16;
            case (band)
                tae_pkg::BAND_COOL: begin
                    if (diff > tae_pkg::HOT_MARGIN) begin
                        band = tae_pkg::BAND_HOT; tone = 1'b1;
                    end else if (diff > 0) band = tae_pkg::BAND_WARM;
                end
                tae_pkg::BAND_WARM: begin
                    if (diff <= 0) band = tae_pkg::BAND_COOL;
                    else if (diff > tae_pkg::HOT_MARGIN) begin
                        band = tae_pkg::BAND_HOT; tone = 1'b1;
                    end
                end
                default: begin
                    if (diff <= 0) band = tae_pkg::BAND_COOL;
                    else if (diff < tae_pkg::HOT_MARGIN) band = tae_pkg::BAND_WARM;
                end
            endcase
            if (tone) hot_entries++;
            if (note < note_lo) note_lo = note;
            if (note > note_hi) note_hi = note;
            if (threshold < thr_lo) thr_lo = threshold;
            if (threshold > thr_hi) thr_hi = threshold;

            r              = '0;
            r.alarm_state  = band;
            r.green_led    = (band == tae_pkg::BAND_COOL);
            r.red_led      = (band == tae_pkg::BAND_HOT);
            r.blink_enable = (band == tae_pkg::BAND_WARM);
            r.tone_start   = tone;
            r.alert_note   = note[tae_pkg::NOTE_W-1:0];
            r.threshold_f  = threshold[tae_pkg::THRESH_W-1:0];
            r.edit_target  = edit_thr;
            r.temp_f16     = temp_f16[tae_pkg::TEMP_W-1:0];
            predicted.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %0d, got %0d",
                             results_seen, name, want, got);
            end
        endfunction

        // Check one accepted result beat against the oldest prediction.
        function void check_result(logic [tae_pkg::M_TDATA_W-1:0] tdata);
            alarm_result_t got;
            alarm_result_t want;
            got = tdata;
            results_seen++;
            if (predicted.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: no result pending, got tdata 0x%h",
                             results_seen, tdata);
                return;
            end
            want = predicted.pop_front();
            compare_field("alarm_state", int'(want.alarm_state), int'(got.alarm_state));
            compare_field("green_led", int'(want.green_led), int'(got.green_led));
            compare_field("red_led", int'(want.red_led), int'(got.red_led));
            compare_field("blink_enable", int'(want.blink_enable), int'(got.blink_enable));
            compare_field("tone_start", int'(want.tone_start), int'(got.tone_start));
            compare_field("alert_note", int'(want.alert_note), int'(got.alert_note));
            compare_field("threshold_f", int'(want.threshold_f), int'(got.threshold_f));
            compare_field("edit_target", int'(want.edit_target), int'(got.edit_target));
            compare_field("temp_f16", int'($signed(want.temp_f16)),
                          int'($signed(got.temp_f16)));
            compare_field("padding", int'(want.pad), int'(got.pad));
        endfunction

        function int pending();
            return predicted.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tae_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [tae_pkg::CMD_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tae_pkg::M_TDATA_W-1:0]  m_tdata;

    alarm_scoreboard sb;
    int  beats_sent;
    int  idle_cycles;
    // Source pacing: a burst stretch sends back to back, otherwise random gaps.
    bit  src_burst;
    int  src_mode_left;
    // Sink pacing: a calm stretch starts no new stall, though one already running finishes.
    bit  sink_calm;
    int  sink_mode_left;
    int  sink_stall;

    temperature_alarm_with_encoder_setting dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Sample both channels at the rising edge; predict first, then check.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog: give up once nothing has moved on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                         IDLE_LIMIT, sb.pending());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result-side backpressure: mostly short stalls, a few long, calm stretches between.
    always @(negedge aclk) begin
        if (sink_mode_left == 0) begin
            sink_calm      = ($urandom_range(0, 3) == 0);
            sink_mode_left = $urandom_range(50, 300);
        end else begin
            sink_mode_left--;
        end
        if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else if (!sink_calm && $urandom_range(0, 99) < 35) begin
            sink_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                     : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [tae_pkg::S_TDATA_W-1:0] pack_beat(
        logic [tae_pkg::RAW_W-1:0] raw, logic a, logic b, logic note_n, logic thr_n);
        return {thr_n, note_n, b, a, raw};
    endfunction

    // Encoder levels that make one clean step from the given phase.
    function automatic logic [1:0] quad_levels(logic [1:0] phase, bit fwd);
        // Returned as {b, a}.
        case (phase)
            ENC_REST: return fwd ? 2'b01 : 2'b10;
            ENC_A:    return fwd ? 2'b11 : 2'b00;
            ENC_AB:   return fwd ? 2'b10 : 2'b01;
            default:  return fwd ? 2'b00 : 2'b11;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (src_mode_left == 0) begin
            src_burst     = ($urandom_range(0, 3) == 0);
            src_mode_left = $urandom_range(40, 200);
        end else begin
            src_mode_left--;
        end
        if (src_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Present one beat at the falling edge and hold it until the block takes it.
    task automatic send_beat(input logic [tae_pkg::CMD_W-1:0] cmd,
                             input logic [tae_pkg::S_TDATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
    endtask

    // Temperature sample, mostly steered to the band edges around the threshold.
    task automatic send_sample();
        int r;
        int target;
        int raw;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            target = sb.threshold * 16 + $urandom_range(0, 96) - 48;
            raw    = ((target - tae_pkg::F_OFFSET) * 5) / 9 + $urandom_range(0, 2) - 1;
        end else if (r < 90) begin
            raw = $urandom_range(0, 2880) - 880;
        end else begin
            raw = $urandom_range(0, 4095) - 2048;
        end
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat((tae_pkg::RAW_W)'(raw), 1'($urandom),
                                                 1'($urandom), 1'($urandom), 1'($urandom)));
    endtask

    // Run of encoder events in one direction, with an occasional glitch or skip.
    task automatic send_encoder_run();
        int         len;
        bit         fwd;
        logic [1:0] ba;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        fwd = 1'($urandom_range(0, 1));
        repeat (len) begin
            if ($urandom_range(0, 99) < 10) ba = 2'($urandom);
            else ba = quad_levels(sb.enc_phase, fwd);
            send_beat(tae_pkg::CMD_ENCODER, pack_beat((tae_pkg::RAW_W)'($urandom), ba[0], ba[1],
                                                      1'($urandom), 1'($urandom)));
        end
    endtask

    task automatic send_buttons();
        int   r;
        logic note_n;
        logic thr_n;
        r = $urandom_range(0, 99);
        if (r < 30)      begin note_n = 1'b0; thr_n = 1'b1; end
        else if (r < 60) begin note_n = 1'b1; thr_n = 1'b0; end
        else if (r < 75) begin note_n = 1'b0; thr_n = 1'b0; end
        else             begin note_n = 1'b1; thr_n = 1'b1; end
        send_beat(tae_pkg::CMD_BUTTONS, pack_beat((tae_pkg::RAW_W)'($urandom), 1'($urandom),
                                                  1'($urandom), note_n, thr_n));
    endtask

    task automatic send_directed();
        // Sample extremes: stated range, then the full 12-bit range.
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd2000, 1'b1, 1'b1, 1'b0, 1'b0));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd2000, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(-12'sd880, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd2047, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(-12'sd2048, 1'b0, 1'b0, 1'b1, 1'b1));
        // Walk the band edges at the reset threshold: warm, hot, warm, exactly on it.
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd428, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd445, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd444, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd427, 1'b0, 1'b0, 1'b1, 1'b1));
        // Unused command with busy data must change nothing.
        send_beat(CMD_UNUSED, 16'hFFFF);
        // Both buttons held: note editing wins.
        send_beat(tae_pkg::CMD_BUTTONS, pack_beat(12'h000, 1'b0, 1'b0, 1'b0, 1'b0));
        // Encoder: a step, a repeat with no step, a skipped phase, a step back.
        send_beat(tae_pkg::CMD_ENCODER, pack_beat(12'h000, 1'b1, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_ENCODER, pack_beat(12'h000, 1'b1, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_ENCODER, pack_beat(12'h000, 1'b0, 1'b1, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_ENCODER, pack_beat(12'h000, 1'b1, 1'b0, 1'b1, 1'b1));
        // Switch to threshold editing, then release both buttons to hold it.
        send_beat(tae_pkg::CMD_BUTTONS, pack_beat(12'h000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_beat(tae_pkg::CMD_BUTTONS, pack_beat(12'h000, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_ENCODER, pack_beat(12'h000, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_ENCODER, pack_beat(12'h000, 1'b0, 1'b1, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_SAMPLE, pack_beat(12'sd445, 1'b0, 1'b0, 1'b1, 1'b1));
        send_beat(tae_pkg::CMD_BUTTONS, pack_beat(12'h000, 1'b0, 1'b0, 1'b0, 1'b1));
        send_beat(CMD_UNUSED, 16'h0000);
    endtask

    initial begin
        int directed_beats;
        int r;
        sb             = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        beats_sent     = 0;
        idle_cycles    = 0;
        src_mode_left  = 0;
        sink_mode_left = 0;
        sink_stall     = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_directed();
        directed_beats = beats_sent;

        // Random part: sensor samples, encoder runs, button changes, some noise.
        while (beats_sent < directed_beats + RANDOM_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 35)      send_sample();
            else if (r < 70) send_encoder_run();
            else if (r < 85) send_buttons();
            else if (r < 92) send_beat(CMD_UNUSED, (tae_pkg::S_TDATA_W)'($urandom));
            else             send_beat((tae_pkg::CMD_W)'($urandom),
                                       (tae_pkg::S_TDATA_W)'($urandom));
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipeline settle to catch any stray result.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d beats: %0d samples, %0d encoder, %0d button, %0d unused",
                 beats_sent, sb.cmd_count[0], sb.cmd_count[1], sb.cmd_count[2],
                 sb.cmd_count[3]);
        $display("%0d hot entries; note swept %0d..%0d, threshold swept %0d..%0d F; %0d results, %0d mismatches",
                 sb.hot_entries, sb.note_lo, sb.note_hi, sb.thr_lo, sb.thr_hi,
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/tae_pkg.sv
hdl/tae_f_convert.sv
hdl/temperature_alarm_with_encoder_setting.sv
dv/tb_top.sv
